// ----- hdl/tlca_pkg.sv -----
// Shared types, constants and helpers for the tree LCA distance engine.
// No dependencies; every other file in hdl/ imports this package.
`default_nettype none

package tlca_pkg;

    localparam int NODE_W     = 10;
    localparam int DEP_W      = 10;
    localparam int DIST_W     = 11;
    localparam int NODES      = 1024;
    localparam int LEVELS_DEF = 10;
    localparam int LVL_MAX_W  = 5;

    localparam logic ACT_ATTACH = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;

    typedef logic [NODE_W-1:0]    t_node;
    typedef logic [DEP_W-1:0]     t_depth;
    typedef logic [DIST_W-1:0]    t_dist;
    typedef logic [LVL_MAX_W-1:0] t_lvl;

    // sequencer -> storage
    typedef struct packed {
        logic   dep_we;
        logic   anc_we;
        t_node  wr_node;
        t_lvl   wr_lvl;
        t_depth wr_dep;
        t_node  wr_anc;
        t_node  rd_node_a;
        t_node  rd_node_b;
        t_lvl   rd_lvl;
    } t_store_req;

    // storage -> sequencer, registered: valid in the cycle after the read address
    typedef struct packed {
        t_node  anc_a;
        t_node  anc_b;
        t_depth dep_a;
        t_depth dep_b;
    } t_store_rsp;

    // depth of a new child, saturating at the deepest legal depth
    function automatic t_depth depth_inc(t_depth d);
        return (d == t_depth'(NODES - 1)) ? d : t_depth'(d + 1'b1);
    endfunction

endpackage

`default_nettype wire

// ----- hdl/tlca_ifs.sv -----
// Valid/ready channel interfaces for the request and response transactions.
// Depends on tlca_pkg for the payload types.
`default_nettype none

interface tlca_in_if import tlca_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  action;
    t_node first_node;
    t_node second_node;

    modport source (output valid, action, first_node, second_node, input ready);
    modport sink   (input valid, action, first_node, second_node, output ready);
endinterface

interface tlca_out_if import tlca_pkg::*; ();
    logic  valid;
    logic  ready;
    t_node common_ancestor;
    t_dist distance;

    modport source (output valid, common_ancestor, distance, input ready);
    modport sink   (input valid, common_ancestor, distance, output ready);
endinterface

`default_nettype wire

// ----- hdl/tlca_store.sv -----
// Ancestor table and depth store with registered reads.
// Depends on tlca_pkg. Node 0 (the root) always reads as root at depth zero.
`default_nettype none

module tlca_store import tlca_pkg::*; #(
    parameter int LEVELS = LEVELS_DEF
) (
    input  logic       i_clk,
    input  t_store_req i_req,
    output t_store_rsp o_rsp
);

    localparam int LW       = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int ANC_ROWS = 1 << (NODE_W + LW);

    t_node  r_anc_mem [0:ANC_ROWS-1];
    t_depth r_dep_mem [0:NODES-1];

    t_node  r_anc_a;
    t_node  r_anc_b;
    t_depth r_dep_a;
    t_depth r_dep_b;
    logic   r_zero_a;
    logic   r_zero_b;

    logic [NODE_W+LW-1:0] wr_addr;
    logic [NODE_W+LW-1:0] rd_addr_a;
    logic [NODE_W+LW-1:0] rd_addr_b;

    assign wr_addr   = {i_req.wr_node,   i_req.wr_lvl[LW-1:0]};
    assign rd_addr_a = {i_req.rd_node_a, i_req.rd_lvl[LW-1:0]};
    assign rd_addr_b = {i_req.rd_node_b, i_req.rd_lvl[LW-1:0]};

    always_ff @(posedge i_clk) begin
        if (i_req.anc_we) begin
            r_anc_mem[wr_addr] <= i_req.wr_anc;
        end
        if (i_req.dep_we) begin
            r_dep_mem[i_req.wr_node] <= i_req.wr_dep;
        end
        r_anc_a  <= r_anc_mem[rd_addr_a];
        r_anc_b  <= r_anc_mem[rd_addr_b];
        r_dep_a  <= r_dep_mem[i_req.rd_node_a];
        r_dep_b  <= r_dep_mem[i_req.rd_node_b];
        r_zero_a <= (i_req.rd_node_a == '0);
        r_zero_b <= (i_req.rd_node_b == '0);
    end

    // the root row is never written: force it to root at depth zero
    assign o_rsp.anc_a = r_zero_a ? '0 : r_anc_a;
    assign o_rsp.anc_b = r_zero_b ? '0 : r_anc_b;
    assign o_rsp.dep_a = r_zero_a ? '0 : r_dep_a;
    assign o_rsp.dep_b = r_zero_b ? '0 : r_dep_b;

endmodule

`default_nettype wire

// ----- hdl/tree_lca_distance.sv -----
// Tree LCA distance engine: top level with the sequencer and output register.
// Depends on tlca_pkg, tlca_ifs (tlca_in_if, tlca_out_if) and tlca_store.
//
// Usage:
//   i_req carries one transaction per item: action, first_node, second_node.
//   An attach (action 0) hangs first_node below second_node, which must be
//   attached already; node 0 is the root and an attach of it is dropped.
//   A query (action 1) returns one o_rsp transaction holding the lowest
//   common ancestor and the path length in edges. An attach returns nothing.
//   i_req.ready is high only while the sequencer is idle; one item at a time.
//   Timing is set by the dependent reads through the single registered
//   ancestor memory (two read ports). An attach writes the child's row one
//   level per read; a query reads both depths, runs the first lift, and
//   runs the second lift only when the nodes still differ after the first.
//   The response sits in an output register; the block takes a new item
//   while it waits. A stalled receiver only holds a later query in its last
//   state until the register frees up.
//   Reset (i_rst_n low, synchronous) returns the sequencer to idle and
//   empties the output register. The memories are not cleared: the root row
//   and root depth are forced to zero on read, so no clearing pass runs.
`default_nettype none

module tree_lca_distance import tlca_pkg::*; #(
    parameter int LEVELS = LEVELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tlca_in_if.sink     i_req,
    tlca_out_if.source  o_rsp
);

    localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ADEP  = 4'd1;   // read parent depth
    localparam logic [3:0] S_ADEPD = 4'd2;   // write depth and level 0
    localparam logic [3:0] S_AREAD = 4'd3;   // read ancestor of current node
    localparam logic [3:0] S_ADATA = 4'd4;   // write next level of the row
    localparam logic [3:0] S_QDEP  = 4'd5;   // read both depths
    localparam logic [3:0] S_QDEPD = 4'd6;   // order nodes, form difference
    localparam logic [3:0] S_L1    = 4'd7;   // first lift: test a bit
    localparam logic [3:0] S_L1D   = 4'd8;   // first lift: take ancestor
    localparam logic [3:0] S_CMP   = 4'd9;
    localparam logic [3:0] S_L2    = 4'd10;  // joint lift: read both
    localparam logic [3:0] S_L2D   = 4'd11;  // joint lift: compare
    localparam logic [3:0] S_TOP   = 4'd12;  // read parent of the meeting pair
    localparam logic [3:0] S_TOPD  = 4'd13;
    localparam logic [3:0] S_LDEP  = 4'd14;  // read depth of the ancestor
    localparam logic [3:0] S_OUT   = 4'd15;  // load the output register

    localparam logic [LW-1:0] LVL_TOP = LW'(LEVELS - 1);

    logic [3:0]    r_state, n_state;
    t_node         r_a, n_a;       // working node A (attach: current ancestor)
    t_node         r_b, n_b;       // working node B
    t_node         r_c, n_c;       // attach: child being filled
    logic [LW-1:0] r_lvl, n_lvl;
    t_depth        r_k, n_k;       // depth difference to lift
    t_depth        r_da, n_da;
    t_depth        r_db, n_db;
    logic          r_o_valid, n_o_valid;
    t_node         r_o_anc, n_o_anc;
    t_dist         r_o_dist, n_o_dist;

    t_store_req    store_req;
    t_store_rsp    store_rsp;
    logic          in_fire;
    logic          out_free;
    t_depth        k_shift;
    t_dist         path_len;

    tlca_store #(
        .LEVELS (LEVELS)
    ) u_store (
        .i_clk (i_clk),
        .i_req (store_req),
        .o_rsp (store_rsp)
    );

    assign in_fire  = i_req.valid && i_req.ready;
    assign out_free = !r_o_valid || o_rsp.ready;
    assign k_shift  = r_k >> r_lvl;

    // path length, wrapped to the output width
    assign path_len = DIST_W'(r_da) - DIST_W'(store_rsp.dep_a)
                    + DIST_W'(r_db) - DIST_W'(store_rsp.dep_a);

    // Reads run every cycle at the working nodes and level; writes target
    // the child row during an attach.
    always_comb begin
        store_req.rd_node_a = r_a;
        store_req.rd_node_b = r_b;
        store_req.rd_lvl    = t_lvl'(r_lvl);
        store_req.wr_node   = r_c;
        store_req.wr_dep    = depth_inc(store_rsp.dep_a);
        store_req.wr_anc    = (r_state == S_ADATA) ? store_rsp.anc_a : r_a;
        store_req.wr_lvl    = (r_state == S_ADATA) ? t_lvl'(r_lvl + 1'b1) : '0;
        store_req.dep_we    = (r_state == S_ADEPD);
        store_req.anc_we    = (r_state == S_ADEPD) || (r_state == S_ADATA);
    end

    always_comb begin
        n_state   = r_state;
        n_a       = r_a;
        n_b       = r_b;
        n_c       = r_c;
        n_lvl     = r_lvl;
        n_k       = r_k;
        n_da      = r_da;
        n_db      = r_db;
        n_o_valid = r_o_valid;
        n_o_anc   = r_o_anc;
        n_o_dist  = r_o_dist;

        if (r_o_valid && o_rsp.ready) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_a = i_req.first_node;
                    n_b = i_req.second_node;
                    if (i_req.action == ACT_QUERY) begin
                        n_state = S_QDEP;
                    end else if (i_req.first_node != '0) begin
                        // current node starts at the parent
                        n_a     = i_req.second_node;
                        n_c     = i_req.first_node;
                        n_state = S_ADEP;
                    end
                end
            end
            S_ADEP: begin
                n_state = S_ADEPD;
            end
            S_ADEPD: begin
                n_lvl   = '0;
                n_state = (LEVELS == 1) ? S_IDLE : S_AREAD;
            end
            S_AREAD: begin
                n_state = S_ADATA;
            end
            S_ADATA: begin
                n_a = store_rsp.anc_a;
                if (({1'b0, r_lvl} + 1'b1) == (LW+1)'(LEVELS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_lvl   = r_lvl + 1'b1;
                    n_state = S_AREAD;
                end
            end
            S_QDEP: begin
                n_state = S_QDEPD;
            end
            S_QDEPD: begin
                // keep the deeper node in A
                if (store_rsp.dep_a < store_rsp.dep_b) begin
                    n_a  = r_b;
                    n_b  = r_a;
                    n_da = store_rsp.dep_b;
                    n_db = store_rsp.dep_a;
                    n_k  = store_rsp.dep_b - store_rsp.dep_a;
                end else begin
                    n_da = store_rsp.dep_a;
                    n_db = store_rsp.dep_b;
                    n_k  = store_rsp.dep_a - store_rsp.dep_b;
                end
                n_lvl   = LVL_TOP;
                n_state = S_L1;
            end
            S_L1: begin
                if (k_shift[0]) begin
                    n_state = S_L1D;
                end else if (r_lvl == '0) begin
                    n_state = S_CMP;
                end else begin
                    n_lvl = r_lvl - 1'b1;
                end
            end
            S_L1D: begin
                n_a = store_rsp.anc_a;
                if (r_lvl == '0) begin
                    n_state = S_CMP;
                end else begin
                    n_lvl   = r_lvl - 1'b1;
                    n_state = S_L1;
                end
            end
            S_CMP: begin
                if (r_a == r_b) begin
                    n_state = S_LDEP;
                end else begin
                    n_lvl   = LVL_TOP;
                    n_state = S_L2;
                end
            end
            S_L2: begin
                n_state = S_L2D;
            end
            S_L2D: begin
                if (store_rsp.anc_a != store_rsp.anc_b) begin
                    n_a = store_rsp.anc_a;
                    n_b = store_rsp.anc_b;
                end
                if (r_lvl == '0) begin
                    n_state = S_TOP;
                end else begin
                    n_lvl   = r_lvl - 1'b1;
                    n_state = S_L2;
                end
            end
            S_TOP: begin
                n_state = S_TOPD;
            end
            S_TOPD: begin
                n_a     = store_rsp.anc_a;
                n_state = S_LDEP;
            end
            S_LDEP: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                // hold until the output register is free
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_anc   = r_a;
                    n_o_dist  = path_len;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
        r_a      <= n_a;
        r_b      <= n_b;
        r_c      <= n_c;
        r_lvl    <= n_lvl;
        r_k      <= n_k;
        r_da     <= n_da;
        r_db     <= n_db;
        r_o_anc  <= n_o_anc;
        r_o_dist <= n_o_dist;
    end

    assign i_req.ready           = (r_state == S_IDLE);
    assign o_rsp.valid           = r_o_valid;
    assign o_rsp.common_ancestor = r_o_anc;
    assign o_rsp.distance        = r_o_dist;

`ifndef SYNTH
    a_query_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_req.action == ACT_QUERY) |=> (r_state == S_QDEP))
        else $error("query transaction did not start the depth read");

    a_rsp_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> ($past(r_state) == S_OUT))
        else $error("response appeared outside the output state");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_o_valid && !o_rsp.ready) |=> (r_state == S_OUT))
        else $error("query finished over an untaken response");

    a_top_level_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TOP) |-> (r_lvl == '0))
        else $error("final parent read not at level zero");

    a_attach_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADATA || r_state == S_ADEPD) |=> !$rose(r_o_valid))
        else $error("attach produced a response");
`endif

endmodule

`default_nettype wire
